// ----- src/crs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_pkg
// Shared types and constants for the Catmull-Rom spline position unit.
// ----------------------------------------------------------------------------
package crs_pkg;

    localparam int COORD_BITS  = 24;
    localparam int T_FRAC_BITS = 16;
    localparam int CFG_BITS    = 7;
    localparam int IDX_BITS    = 6;
    localparam int SEG_BITS    = 6;

    localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    typedef enum logic {
        REG_POINT_COUNT = 1'b0,
        REG_LOOP_MODE   = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_LERP,
        MODE_CUBIC
    } mode_t;

    typedef struct packed {
        logic                          kind;
        logic [IDX_BITS-1:0]           point_index;
        logic signed [COORD_BITS-1:0]  point_x;
        logic signed [COORD_BITS-1:0]  point_y;
        logic [T_FRAC_BITS:0]          param_t;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  curve_x;
        logic signed [COORD_BITS-1:0]  curve_y;
        logic [SEG_BITS-1:0]           segment;
    } out_item_t;

    typedef struct packed {
        logic                  valid;
        mode_t                 mode;
        logic [SEG_BITS-1:0]   seg;
        logic [T_FRAC_BITS:0]  lt;
    } eval_ctl_t;

endpackage

// ----- src/crs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module crs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/crs_addr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_addr
// Splits the global parameter over the segments and forms the four
// neighbour addresses and the local parameter.
// ----------------------------------------------------------------------------
module crs_addr #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       en,
    input  logic                                       eval_valid,
    input  logic [crs_pkg::T_FRAC_BITS:0]              param_t,
    input  logic [crs_pkg::CFG_BITS-1:0]               point_count,
    input  logic                                       loop_mode,
    output logic [3:0][$clog2(MAX_POINTS)-1:0]         raddr,
    output crs_pkg::eval_ctl_t                         ctl
);

    localparam int F  = crs_pkg::T_FRAC_BITS;
    localparam int IW = $clog2(MAX_POINTS);
    localparam int NW = IW + 1;
    localparam int SW = F + 1 + NW;

    logic [F:0]          tsat;
    logic [NW-1:0]       n0;
    logic [NW-1:0]       segs0;
    crs_pkg::mode_t      mode0;
    logic [SW-1:0]       st0;

    logic                v1_reg;
    crs_pkg::mode_t      mode1_reg;
    logic [NW-1:0]       n1_reg;
    logic [NW-1:0]       segs1_reg;
    logic [F:0]          t1_reg;
    logic [SW-1:0]       st1_reg;
    logic                wrap1_reg;

    logic [NW:0]         segq;
    logic [NW-1:0]       k;
    logic [NW:0]         k1;
    logic [NW:0]         k2;
    logic [NW:0]         nn;
    logic [NW:0]         i0;
    logic [NW:0]         i1;
    logic [NW:0]         i2;
    logic [NW:0]         i3;
    logic [F:0]          lt;

    crs_pkg::eval_ctl_t  ctl_next;
    crs_pkg::eval_ctl_t  ctl_reg;

    always_comb
    begin
        tsat = (param_t > crs_pkg::T_ONE) ? crs_pkg::T_ONE : param_t;
        if (32'(point_count) > 32'(MAX_POINTS))
        begin
            n0 = NW'(MAX_POINTS);
        end
        else
        begin
            n0 = NW'(point_count);
        end
        if (n0 < NW'(2))
        begin
            mode0 = crs_pkg::MODE_ZERO;
        end
        else if (n0 == NW'(2))
        begin
            mode0 = crs_pkg::MODE_LERP;
        end
        else
        begin
            mode0 = crs_pkg::MODE_CUBIC;
        end
        segs0 = loop_mode ? n0 : n0 - NW'(1);
        st0   = SW'(tsat) * SW'(segs0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= eval_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode1_reg <= mode0;
            n1_reg    <= n0;
            segs1_reg <= segs0;
            t1_reg    <= tsat;
            st1_reg   <= st0;
            wrap1_reg <= loop_mode;
        end
    end

    always_comb
    begin
        segq = st1_reg[SW-1:F];
        if (segq >= {1'b0, segs1_reg})
        begin
            k  = segs1_reg - NW'(1);
            lt = crs_pkg::T_ONE;
        end
        else
        begin
            k  = segq[NW-1:0];
            lt = {1'b0, st1_reg[F-1:0]};
        end
        nn = {1'b0, n1_reg};
        k1 = {1'b0, k} + (NW+1)'(1);
        k2 = {1'b0, k} + (NW+1)'(2);
        i1 = {1'b0, k};
        if (wrap1_reg)
        begin
            i0 = (k == '0) ? nn - (NW+1)'(1) : {1'b0, k} - (NW+1)'(1);
            i2 = (k1 >= nn) ? k1 - nn : k1;
            i3 = (k2 >= nn) ? k2 - nn : k2;
        end
        else
        begin
            i0 = (k == '0) ? '0 : {1'b0, k} - (NW+1)'(1);
            i2 = (k1 > nn - (NW+1)'(1)) ? nn - (NW+1)'(1) : k1;
            i3 = (k2 > nn - (NW+1)'(1)) ? nn - (NW+1)'(1) : k2;
        end

        ctl_next.valid = v1_reg;
        ctl_next.mode  = mode1_reg;
        ctl_next.seg   = '0;
        ctl_next.lt    = t1_reg;
        case (mode1_reg)
            crs_pkg::MODE_CUBIC:
            begin
                ctl_next.seg = crs_pkg::SEG_BITS'(k);
                ctl_next.lt  = lt;
            end
            crs_pkg::MODE_LERP:
            begin
                i1 = '0;
                i2 = (NW+1)'(1);
            end
            default:
            begin
                ctl_next.lt = t1_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    assign raddr[0] = i0[IW-1:0];
    assign raddr[1] = i1[IW-1:0];
    assign raddr[2] = i2[IW-1:0];
    assign raddr[3] = i3[IW-1:0];
    assign ctl      = ctl_reg;

endmodule

// ----- src/crs_cubic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_cubic
// Six stage exact evaluation of the cubic for one coordinate, floored and
// saturated.
// ----------------------------------------------------------------------------
module crs_cubic (
    input  logic                                  clk,
    input  logic                                  en,
    input  crs_pkg::mode_t                        mode,
    input  logic [crs_pkg::T_FRAC_BITS:0]         lt,
    input  logic signed [crs_pkg::COORD_BITS-1:0] p0,
    input  logic signed [crs_pkg::COORD_BITS-1:0] p1,
    input  logic signed [crs_pkg::COORD_BITS-1:0] p2,
    input  logic signed [crs_pkg::COORD_BITS-1:0] p3,
    output logic signed [crs_pkg::COORD_BITS-1:0] result
);

    localparam int W    = crs_pkg::COORD_BITS;
    localparam int F    = crs_pkg::T_FRAC_BITS;
    localparam int CW   = W + 5;
    localparam int TW   = F + 2;
    localparam int HW   = W + F + 7;
    localparam int QW   = HW - F;
    localparam int PW   = QW + TW;
    localparam int RPW  = 2 * F + 3;
    localparam int H2W  = PW + 1;
    localparam int Q3W  = H2W - F;
    localparam int M1W  = Q3W + TW;
    localparam int VW   = M1W + 1;
    localparam int RESW = VW - F - 1;

    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    logic signed [CW-1:0]  pe0, pe1, pe2, pe3;
    logic signed [CW-1:0]  a, b, c, d;
    logic signed [TW-1:0]  ts;

    logic signed [CW-1:0]  a3_reg, b3_reg, c3_reg, d3_reg;
    logic signed [TW-1:0]  t3_reg;
    logic signed [HW-1:0]  h1;

    logic signed [HW-1:0]  h1_4_reg;
    logic signed [CW-1:0]  c4_reg, d4_reg;
    logic signed [TW-1:0]  t4_reg;
    logic signed [QW-1:0]  q1;
    logic signed [F:0]     r1;
    logic signed [PW-1:0]  mq;
    logic signed [RPW-1:0] mr;

    logic signed [PW-1:0]  mq5_reg;
    logic signed [RPW-1:0] mr5_reg;
    logic signed [CW-1:0]  c5_reg, d5_reg;
    logic signed [TW-1:0]  t5_reg;
    logic signed [H2W-1:0] h2;

    logic signed [H2W-1:0] h2_6_reg;
    logic [F-1:0]          e6_reg;
    logic signed [CW-1:0]  d6_reg;
    logic signed [TW-1:0]  t6_reg;
    logic signed [Q3W-1:0] q3;
    logic signed [F:0]     r3;
    logic signed [M1W-1:0] m1;
    logic signed [RPW-1:0] m2;

    logic signed [M1W-1:0] m1_7_reg;
    logic signed [RPW-1:0] m2_7_reg;
    logic signed [CW-1:0]  d7_reg;
    logic signed [VW-1:0]  v;
    logic signed [RESW-1:0] res;
    logic signed [W-1:0]   sat;

    logic signed [W-1:0]   result_reg;

    always_comb
    begin
        pe0 = CW'(p0);
        pe1 = CW'(p1);
        pe2 = CW'(p2);
        pe3 = CW'(p3);
        ts  = $signed({1'b0, lt});
        case (mode)
            crs_pkg::MODE_CUBIC:
            begin
                a = pe3 - pe0 + (pe1 <<< 1) + pe1 - (pe2 <<< 1) - pe2;
                b = (pe0 <<< 1) - (pe1 <<< 2) - pe1 + (pe2 <<< 2) - pe3;
                c = pe2 - pe0;
                d = pe1 <<< 1;
            end
            crs_pkg::MODE_LERP:
            begin
                a = '0;
                b = '0;
                c = (pe2 - pe1) <<< 1;
                d = pe1 <<< 1;
            end
            default:
            begin
                a = '0;
                b = '0;
                c = '0;
                d = '0;
            end
        endcase
    end

    always_comb
    begin
        h1 = HW'(a3_reg) * HW'(t3_reg) + (HW'(b3_reg) <<< F);
        q1 = $signed(h1_4_reg[HW-1:F]);
        r1 = $signed({1'b0, h1_4_reg[F-1:0]});
        mq = PW'(q1) * PW'(t4_reg);
        mr = RPW'(r1) * RPW'(t4_reg);
        h2 = H2W'(mq5_reg) + (H2W'(c5_reg) <<< F) + H2W'($signed(mr5_reg[RPW-1:F]));
        q3 = $signed(h2_6_reg[H2W-1:F]);
        r3 = $signed({1'b0, h2_6_reg[F-1:0]});
        m1 = M1W'(q3) * M1W'(t6_reg);
        m2 = RPW'(r3) * RPW'(t6_reg) + RPW'($signed({1'b0, e6_reg}));
        v  = VW'(m1_7_reg) + VW'($signed(m2_7_reg[RPW-1:F])) + (VW'(d7_reg) <<< F);
        res = $signed(v[VW-1:F+1]);
        if (res > RESW'(WMAX))
        begin
            sat = WMAX;
        end
        else if (res < RESW'(WMIN))
        begin
            sat = WMIN;
        end
        else
        begin
            sat = res[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a3_reg     <= a;
            b3_reg     <= b;
            c3_reg     <= c;
            d3_reg     <= d;
            t3_reg     <= ts;
            h1_4_reg   <= h1;
            c4_reg     <= c3_reg;
            d4_reg     <= d3_reg;
            t4_reg     <= t3_reg;
            mq5_reg    <= mq;
            mr5_reg    <= mr;
            c5_reg     <= c4_reg;
            d5_reg     <= d4_reg;
            t5_reg     <= t4_reg;
            h2_6_reg   <= h2;
            e6_reg     <= mr5_reg[F-1:0];
            d6_reg     <= d5_reg;
            t6_reg     <= t5_reg;
            m1_7_reg   <= m1;
            m2_7_reg   <= m2;
            d7_reg     <= d6_reg;
            result_reg <= sat;
        end
    end

    assign result = result_reg;

endmodule

// ----- src/catmull_rom_spline_position.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_spline_position
// Uniform Catmull-Rom spline position unit over a table of 2D points.
// ----------------------------------------------------------------------------
// usage
//   cfg_write/cfg_index/cfg_data set point_count and loop_mode while idle.
//   in_valid/in_stall carry requests: kind 0 writes point_x/point_y at
//   point_index, kind 1 evaluates the curve at param_t.
//   out_valid/out_stall return one result per evaluate request, in order;
//   write requests return nothing and are seen by the next request.
//   a result shows on out_valid after the registers that follow its
//   request: address (loaded at the edge that takes it), table read,
//   coefficient, the arithmetic registers, and the output register last.
//   throughput: one request per cycle while out_stall does not hold the
//   pipeline; four table copies, one per neighbour point, give the four
//   reads each cycle.
//   reset clears the registers and the pipeline valid bits; the table
//   holds garbage until written.
//   while a result waits under out_stall the whole pipeline holds and
//   in_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module catmull_rom_spline_position #(
    parameter int MAX_POINTS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic                           cfg_index,
    input  logic [crs_pkg::CFG_BITS-1:0]   cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  crs_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output crs_pkg::out_item_t             out_data
);

    localparam int W     = crs_pkg::COORD_BITS;
    localparam int IW    = $clog2(MAX_POINTS);
    localparam int DEPTH = 6;

    logic [crs_pkg::CFG_BITS-1:0] count_reg;
    logic                         loop_reg;

    logic                         en;
    logic                         accept;
    logic                         wr;
    logic                         eval_valid;
    logic [2*W-1:0]               wdata;
    logic [3:0][IW-1:0]           raddr;
    logic [3:0][2*W-1:0]          rdata;
    crs_pkg::eval_ctl_t           s2_ctl;
    logic signed [W-1:0]          cx;
    logic signed [W-1:0]          cy;

    logic [DEPTH-1:0]             vld_reg;
    logic [DEPTH-1:0][crs_pkg::SEG_BITS-1:0] seg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            loop_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                crs_pkg::REG_POINT_COUNT: count_reg <= cfg_data;
                crs_pkg::REG_LOOP_MODE:   loop_reg  <= cfg_data[0];
                default:                  count_reg <= count_reg;
            endcase
        end
    end

    assign en         = !(out_valid && out_stall);
    assign in_stall   = !en;
    assign accept     = in_valid && en;
    assign wr         = accept && (in_data.kind == crs_pkg::KIND_WRITE)
                        && (32'(in_data.point_index) < 32'(MAX_POINTS));
    assign eval_valid = accept && (in_data.kind == crs_pkg::KIND_EVAL);
    assign wdata      = {in_data.point_y, in_data.point_x};

    crs_addr #(
        .MAX_POINTS (MAX_POINTS)
    ) u_addr (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .eval_valid  (eval_valid),
        .param_t     (in_data.param_t),
        .point_count (count_reg),
        .loop_mode   (loop_reg),
        .raddr       (raddr),
        .ctl         (s2_ctl)
    );

    for (genvar g = 0; g < 4; g++)
    begin : g_tab
        crs_ram #(
            .WIDTH (2 * W),
            .DEPTH (MAX_POINTS)
        ) u_ram (
            .clk   (clk),
            .we    (wr),
            .waddr (IW'(in_data.point_index)),
            .wdata (wdata),
            .re    (en),
            .raddr (raddr[g]),
            .rdata (rdata[g])
        );
    end

    crs_cubic u_cubic_x (
        .clk    (clk),
        .en     (en),
        .mode   (s2_ctl.mode),
        .lt     (s2_ctl.lt),
        .p0     ($signed(rdata[0][W-1:0])),
        .p1     ($signed(rdata[1][W-1:0])),
        .p2     ($signed(rdata[2][W-1:0])),
        .p3     ($signed(rdata[3][W-1:0])),
        .result (cx)
    );

    crs_cubic u_cubic_y (
        .clk    (clk),
        .en     (en),
        .mode   (s2_ctl.mode),
        .lt     (s2_ctl.lt),
        .p0     ($signed(rdata[0][2*W-1:W])),
        .p1     ($signed(rdata[1][2*W-1:W])),
        .p2     ($signed(rdata[2][2*W-1:W])),
        .p3     ($signed(rdata[3][2*W-1:W])),
        .result (cy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], s2_ctl.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_reg <= {seg_reg[DEPTH-2:0], s2_ctl.seg};
        end
    end

    assign out_valid        = vld_reg[DEPTH-1];
    assign out_data.curve_x = cx;
    assign out_data.curve_y = cy;
    assign out_data.segment = seg_reg[DEPTH-1];

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled result dropped");

    a_no_accept_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("request taken while output stalled");

    a_seg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s2_ctl.valid && (s2_ctl.mode != crs_pkg::MODE_CUBIC) |-> s2_ctl.seg == '0)
        else $error("nonzero segment outside cubic mode");

    a_lt_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_ctl.valid |-> s2_ctl.lt <= crs_pkg::T_ONE)
        else $error("local parameter above one");

endmodule

// ----- bench/tb_catmull_rom_spline_position.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_catmull_rom_spline_position
// Self-checking bench for the Catmull-Rom spline position unit: point writes
// and evaluations under random idling on both sides, checked in order against
// a scoreboard that tracks the point table and the register settings.
// ----------------------------------------------------------------------------
module tb_catmull_rom_spline_position;

    localparam int CW  = crs_pkg::COORD_BITS;
    localparam int IW  = crs_pkg::IDX_BITS;
    localparam int TW  = crs_pkg::T_FRAC_BITS + 1;
    localparam int CFW = crs_pkg::CFG_BITS;
    localparam int ONE = 65536;

    class curve_scoreboard;
        longint px[64];
        longint py[64];
        longint count_reg;
        bit loop_reg;
        crs_pkg::out_item_t pending[$];
        int errors;

        function new();
            for (int i = 0; i < 64; i++)
            begin
                px[i] = 0;
                py[i] = 0;
            end
            count_reg = 0;
            loop_reg = 0;
            errors = 0;
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        function longint fl_shr(longint v, int k);
            if (v >= 0)
                return v >>> k;
            return -((-v - 1) >>> k) - 1;
        endfunction

        function longint clip(longint v);
            longint hi;
            hi = (64'sd1 <<< (CW - 1)) - 1;
            if (v > hi)
                return hi;
            if (v < -hi - 1)
                return -hi - 1;
            return v;
        endfunction

        function longint cubic(longint p0, longint p1, longint p2, longint p3, longint t);
            longint a, b, c, d, h1, q1, r1, h2, e, q3, r3, v;
            a = -p0 + 3 * p1 - 3 * p2 + p3;
            b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
            c = p2 - p0;
            d = 2 * p1;
            h1 = a * t + b * ONE;
            q1 = fl_shr(h1, 16);
            r1 = h1 - q1 * ONE;
            h2 = q1 * t + c * ONE + ((r1 * t) >>> 16);
            e = (r1 * t) & (ONE - 1);
            q3 = fl_shr(h2, 16);
            r3 = h2 - q3 * ONE;
            v = q3 * t + ((r3 * t + e) >>> 16) + d * ONE;
            return fl_shr(v, 17);
        endfunction

        function longint neighbor(longint idx, longint n, bit wrap);
            if (wrap)
                return (idx + n) % n;
            if (idx < 0)
                return 0;
            if (idx > n - 1)
                return n - 1;
            return idx;
        endfunction

        function void note_config(crs_pkg::reg_index_t idx, logic [CFW-1:0] val);
            if (idx == crs_pkg::REG_POINT_COUNT)
                count_reg = longint'(val);
            else
                loop_reg = val[0];
        endfunction

        function void note_request(crs_pkg::in_item_t it);
            crs_pkg::out_item_t r;
            longint n, t, segs, seg, lt;
            longint i0, i1, i2, i3;
            if (it.kind == crs_pkg::KIND_WRITE)
            begin
                px[it.point_index] = longint'(it.point_x);
                py[it.point_index] = longint'(it.point_y);
                return;
            end
            n = count_reg > 64 ? 64 : count_reg;
            t = longint'(it.param_t);
            if (t > ONE)
                t = ONE;
            r = '0;
            if (n == 2)
            begin
                r.curve_x = CW'(clip(fl_shr(px[0] * ONE + t * (px[1] - px[0]), 16)));
                r.curve_y = CW'(clip(fl_shr(py[0] * ONE + t * (py[1] - py[0]), 16)));
            end
            else if (n > 2)
            begin
                segs = loop_reg ? n : n - 1;
                seg = (t * segs) >>> 16;
                lt = (t * segs) & (ONE - 1);
                if (seg >= segs)
                begin
                    seg = segs - 1;
                    lt = ONE;
                end
                i0 = neighbor(seg - 1, n, loop_reg);
                i1 = neighbor(seg, n, loop_reg);
                i2 = neighbor(seg + 1, n, loop_reg);
                i3 = neighbor(seg + 2, n, loop_reg);
                r.curve_x = CW'(clip(cubic(px[i0], px[i1], px[i2], px[i3], lt)));
                r.curve_y = CW'(clip(cubic(py[i0], py[i1], py[i2], py[i3], lt)));
                r.segment = seg[5:0];
            end
            pending.push_back(r);
        endfunction

        task check_result(crs_pkg::out_item_t got);
            crs_pkg::out_item_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            want = pending.pop_front();
            if (got.curve_x !== want.curve_x)
                report($sformatf("curve_x got %0d want %0d", got.curve_x, want.curve_x));
            if (got.curve_y !== want.curve_y)
                report($sformatf("curve_y got %0d want %0d", got.curve_y, want.curve_y));
            if (got.segment !== want.segment)
                report($sformatf("segment got %0d want %0d", got.segment, want.segment));
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_write = 0;
    logic cfg_index = 0;
    logic [CFW-1:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_stall;
    crs_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 0;
    crs_pkg::out_item_t out_data;

    curve_scoreboard board;
    bit calm = 0;
    int hold_long = 0;
    int idle_cycles = 0;

    always #4 clk = ~clk;

    catmull_rom_spline_position u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_data);
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver stall bursts
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (hold_long > 0)
            begin
                out_stall <= 1;
                repeat (hold_long) @(negedge clk);
                hold_long = 0;
                out_stall <= 0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 17);
                out_stall <= 1;
                repeat (n) @(negedge clk);
                out_stall <= 0;
            end
        end
    end

    task automatic send(crs_pkg::in_item_t it);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_data <= it;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(it);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic set_reg(crs_pkg::reg_index_t idx, int val);
        drain();
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= CFW'(val);
        @(negedge clk);
        cfg_write <= 0;
        board.note_config(idx, CFW'(val));
    endtask

    function automatic crs_pkg::in_item_t wr_item(int idx, int x, int y);
        crs_pkg::in_item_t it;
        it = '0;
        it.kind = crs_pkg::KIND_WRITE;
        it.point_index = IW'(idx);
        it.point_x = CW'(x);
        it.point_y = CW'(y);
        it.param_t = TW'($urandom);
        return it;
    endfunction

    function automatic crs_pkg::in_item_t ev_item(int t);
        crs_pkg::in_item_t it;
        it = '0;
        it.kind = crs_pkg::KIND_EVAL;
        it.point_index = IW'($urandom);
        it.point_x = CW'($urandom);
        it.point_y = CW'($urandom);
        it.param_t = TW'(t);
        return it;
    endfunction

    function automatic int rand_t();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return ONE;
            2: return $urandom_range(ONE + 1, 131071);
            default: return $urandom_range(0, ONE);
        endcase
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 4))
            0: return -8388608;
            1: return 8388607;
            2: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    task automatic fill(int n);
        for (int i = 0; i < n; i++)
            send(wr_item(i, rand_coord(), rand_coord()));
    endtask

    initial
    begin
        int cnt;
        board = new();
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: empty table, then extremes
        send(ev_item(0));
        send(ev_item(131071));
        send(wr_item(0, -8388608, 8388607));
        send(wr_item(1, 8388607, -8388608));
        set_reg(crs_pkg::REG_POINT_COUNT, 1);
        send(ev_item(ONE));
        set_reg(crs_pkg::REG_POINT_COUNT, 2);
        send(ev_item(0));
        send(ev_item(ONE / 2));
        send(ev_item(ONE));
        send(ev_item(131071));
        send(wr_item(2, 8388607, 8388607));
        send(wr_item(3, -8388608, -8388608));
        set_reg(crs_pkg::REG_POINT_COUNT, 4);
        send(ev_item(0));
        send(ev_item(ONE / 3));
        send(ev_item(ONE));
        set_reg(crs_pkg::REG_LOOP_MODE, 1);
        send(ev_item(ONE - 1));
        send(ev_item(ONE));
        send(ev_item(131071));
        fill(64);
        set_reg(crs_pkg::REG_POINT_COUNT, 64);
        send(ev_item(ONE));
        send(ev_item(ONE - 1));
        set_reg(crs_pkg::REG_POINT_COUNT, 127);
        send(ev_item(ONE));
        set_reg(crs_pkg::REG_LOOP_MODE, 0);
        send(ev_item(ONE));

        // long receiver hold-off with the sender still pushing
        hold_long = 200;
        for (int i = 0; i < 40; i++)
            send(ev_item(rand_t()));

        for (int ph = 0; ph < 14; ph++)
        begin
            if (ph == 12)
                calm = 1;
            case ($urandom_range(0, 4))
                0: cnt = $urandom_range(0, 3);
                1: cnt = 64;
                2: cnt = 127;
                default: cnt = $urandom_range(3, 12);
            endcase
            set_reg(crs_pkg::REG_LOOP_MODE, $urandom_range(0, 1));
            set_reg(crs_pkg::REG_POINT_COUNT, cnt);
            for (int i = 0; i < 60; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send(wr_item($urandom_range(0, 63), rand_coord(), rand_coord()));
                else
                    send(ev_item(rand_t()));
            end
        end

        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
